// ----- hdl/drk_pkg.sv -----
// Shared constants, types and helper functions for the dead-reckoning integrator.
package drk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int RES_W  = ANGLE_BITS + 2;
  localparam int VEC_W  = 34;
  localparam int OP_W   = 32;
  localparam int PROD_W = 2 * OP_W;

  localparam int POS_W  = 48;
  localparam int HEAD_W = 16;
  localparam int LIN_W  = 16;
  localparam int ANG_W  = 24;
  localparam int DT_W   = 16;

  // Product of cos (Q2.30), speed (Q8.8) and time (Q0.16) is scaled by 2^-54;
  // dropping this many bits leaves Q10.16.
  localparam int OUT_SHIFT = 38;
  localparam int DISP_W    = PROD_W - OUT_SHIFT;

  localparam logic signed [VEC_W-1:0] GAIN_Q30 = VEC_W'(652032875);
  localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W - 1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W - 1){1'b0}}};

  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } cordic_ctrl_t;

  // Arctangent of 2^-idx, rounded half up to ANGLE_BITS bits per turn.
  function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] idx);
    logic [32:0] base;
    logic [32:0] rnd;
    unique case (idx)
      5'd0:    base = 33'd536870912;
      5'd1:    base = 33'd316933406;
      5'd2:    base = 33'd167458907;
      5'd3:    base = 33'd85004756;
      5'd4:    base = 33'd42667331;
      5'd5:    base = 33'd21354465;
      5'd6:    base = 33'd10679838;
      5'd7:    base = 33'd5340245;
      5'd8:    base = 33'd2670163;
      5'd9:    base = 33'd1335087;
      5'd10:   base = 33'd667544;
      5'd11:   base = 33'd333772;
      5'd12:   base = 33'd166886;
      5'd13:   base = 33'd83443;
      5'd14:   base = 33'd41721;
      5'd15:   base = 33'd20861;
      5'd16:   base = 33'd10430;
      5'd17:   base = 33'd5215;
      5'd18:   base = 33'd2608;
      5'd19:   base = 33'd1304;
      5'd20:   base = 33'd652;
      5'd21:   base = 33'd326;
      5'd22:   base = 33'd163;
      5'd23:   base = 33'd81;
      default: base = 33'd0;
    endcase
    rnd = base + (33'd1 << (31 - ANGLE_BITS));
    return ANGLE_BITS'(rnd >> (32 - ANGLE_BITS));
  endfunction

  // Round the scaled displacement to 16 fraction bits and add it to a Q32.16 position, saturating.
  function automatic logic signed [POS_W-1:0] pos_accum(
    input logic signed [POS_W-1:0]  pos,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [DISP_W-1:0] disp;
    logic signed [POS_W:0]    sum;
    logic signed [POS_W-1:0]  res;
    disp = $signed(prod[PROD_W-1:OUT_SHIFT]) + $signed({{(DISP_W - 1){1'b0}},
                                                       prod[OUT_SHIFT-1]});
    sum  = (POS_W + 1)'(pos) + (POS_W + 1)'(disp);
    if (sum[POS_W] != sum[POS_W-1]) begin
      res = sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/drk_mult.sv -----
// Shared signed multiplier with a registered product.
module drk_mult import drk_pkg::*; (
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   op_a,
  input  logic signed [OP_W-1:0]   op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ----- hdl/drk_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of the heading, one step a cycle while ctrl.step is high.
module drk_cordic import drk_pkg::*; (
  input  logic                   clk,
  input  cordic_ctrl_t           ctrl,
  input  logic [HEAD_W-1:0]      heading,
  output logic signed [OP_W-1:0] cos_out,
  output logic signed [OP_W-1:0] sin_out,
  output logic                   flip
);

  localparam logic signed [RES_W-1:0] QUARTER     = RES_W'(2 ** (ANGLE_BITS - 2));
  localparam logic signed [RES_W-1:0] HALF        = RES_W'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [RES_W-1:0] NEG_QUARTER = -QUARTER;

  logic signed [VEC_W-1:0]      x;
  logic signed [VEC_W-1:0]      y;
  logic signed [RES_W-1:0]      a;
  logic [39:0]                  wide;
  logic signed [ANGLE_BITS-1:0] ang_s;
  logic signed [RES_W-1:0]      a0;
  logic signed [RES_W-1:0]      a_init;
  logic                         flip_init;
  logic signed [VEC_W-1:0]      xs;
  logic signed [VEC_W-1:0]      ys;
  logic signed [RES_W-1:0]      t;

  // Rescale the 16-bit heading to ANGLE_BITS per turn and fold it into
  // the right half plane; a folded angle gives negated results.
  always_comb begin
    wide   = {heading, 24'b0};
    ang_s  = $signed(wide[39 -: ANGLE_BITS]);
    a0     = RES_W'(ang_s);
    priority if (a0 > QUARTER) begin
      a_init    = a0 - HALF;
      flip_init = 1'b1;
    end else if (a0 < NEG_QUARTER) begin
      a_init    = a0 + HALF;
      flip_init = 1'b1;
    end else begin
      a_init    = a0;
      flip_init = 1'b0;
    end
  end

  always_comb begin
    xs = x >>> ctrl.idx;
    ys = y >>> ctrl.idx;
    t  = $signed({2'b00, atan_step(5'(ctrl.idx))});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x    <= GAIN_Q30;
      y    <= '0;
      a    <= a_init;
      flip <= flip_init;
    end else if (ctrl.step) begin
      if (a >= 0) begin
        x <= x - ys;
        y <= y + xs;
        a <= a - t;
      end else begin
        x <= x + ys;
        y <= y - xs;
        a <= a + t;
      end
    end
  end

  assign cos_out = x[OP_W-1:0];
  assign sin_out = y[OP_W-1:0];

endmodule

// ----- hdl/dead_reckoning_integrator.sv -----
// Dead-reckoning integrator: top level with the sequencer and pose registers.
// A result passes through S_HEAD, S_TURN, S_LOAD, S_ROT, S_MULX, S_MULY, S_ADDY and S_DONE.
// A new transaction is taken only in S_IDLE, once the last result has left S_DONE;
// the CORDIC steps one iteration a cycle while in S_ROT, and one shared
// multiplier serves the heading step, speed times time and both displacements.
// Reset (synchronous, active high) clears the pose, the held command and all handshakes.
module dead_reckoning_integrator import drk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [LIN_W-1:0]  linear_velocity,
  input  logic signed [ANG_W-1:0]  angular_velocity,
  input  logic [DT_W-1:0]          delta_t,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  position_x,
  output logic signed [POS_W-1:0]  position_y,
  output logic [HEAD_W-1:0]        heading,
  output logic signed [LIN_W-1:0]  echo_linear,
  output logic signed [ANG_W-1:0]  echo_angular
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_TURN,
    S_LOAD,
    S_ROT,
    S_MULX,
    S_MULY,
    S_ADDY,
    S_DONE
  } state_t;

  state_t                   state;
  logic [STEP_W-1:0]        cnt;
  logic signed [LIN_W-1:0]  cmd_lin;
  logic signed [ANG_W-1:0]  cmd_ang;
  logic [DT_W-1:0]          dt_q;
  logic signed [LIN_W-1:0]  held_lin;
  logic signed [ANG_W-1:0]  held_ang;
  logic signed [POS_W-1:0]  pose_x;
  logic signed [POS_W-1:0]  pose_y;
  logic [HEAD_W-1:0]        pose_hd;
  logic signed [OP_W-1:0]   vdt;

  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [OP_W-1:0]   cos_v;
  logic signed [OP_W-1:0]   sin_v;
  logic                     flip;
  logic [HEAD_W-1:0]        hd_step;
  cordic_ctrl_t             cctl;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_HEAD: begin
        op_a = OP_W'(held_ang);
        op_b = $signed(OP_W'(dt_q));
      end
      S_TURN: begin
        op_a = OP_W'(held_lin);
        op_b = $signed(OP_W'(dt_q));
      end
      S_MULY: begin
        op_a = sin_v;
        op_b = vdt;
      end
      default: begin
        op_a = cos_v;
        op_b = vdt;
      end
    endcase
  end

  // Heading increment: angular rate times time, rounded half up, modulo one turn.
  assign hd_step = prod[DT_W +: HEAD_W] + HEAD_W'(prod[DT_W-1]);

  always_comb begin
    cctl.load = (state == S_LOAD);
    cctl.step = (state == S_ROT);
    cctl.idx  = cnt;
  end

  drk_mult u_mult (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  drk_cordic u_cordic (
    .clk     (clk),
    .ctrl    (cctl),
    .heading (pose_hd),
    .cos_out (cos_v),
    .sin_out (sin_v),
    .flip    (flip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      held_lin  <= '0;
      held_ang  <= '0;
      pose_x    <= '0;
      pose_y    <= '0;
      pose_hd   <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_lin <= linear_velocity;
            cmd_ang <= angular_velocity;
            dt_q    <= delta_t;
            state   <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_TURN;
        end
        S_TURN: begin
          pose_hd <= pose_hd + hd_step;
          state   <= S_LOAD;
        end
        S_LOAD: begin
          vdt   <= prod[OP_W-1:0];
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          // A folded angle negates cos and sin; negating the speed term is exact.
          if (cnt == '0 && flip) begin
            vdt <= -vdt;
          end
          if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_MULX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MULX: begin
          state <= S_MULY;
        end
        S_MULY: begin
          pose_x <= pos_accum(pose_x, prod);
          state  <= S_ADDY;
        end
        S_ADDY: begin
          pose_y <= pos_accum(pose_y, prod);
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            position_x   <= pose_x;
            position_y   <= pose_y;
            heading      <= pose_hd;
            echo_linear  <= cmd_lin;
            echo_angular <= cmd_ang;
            held_lin     <= cmd_lin;
            held_ang     <= cmd_ang;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/drk_checker.sv -----
// Port-level checker for the dead-reckoning integrator, bound to the top level.
module drk_checker import drk_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] position_x,
  input logic [HEAD_W-1:0]       heading
);

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // A new result appears only at the end of the work, never while idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction being processed");

  // An accepted input cannot produce its result in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position_x) && $stable(heading))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the handshakes");

endmodule

bind dead_reckoning_integrator drk_checker u_drk_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .position_x (position_x),
  .heading    (heading)
);
